// ===== design/lcdns_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdns_pkg - character LCD nibble sequencer shared definitions
// Request and transfer types, request codes, command bytes and decimal helpers.
// ----------------------------------------------------------------------------
package lcdns_pkg;

  localparam logic [2:0] FUNC_CMD      = 3'd0;
  localparam logic [2:0] FUNC_CHAR     = 3'd1;
  localparam logic [2:0] FUNC_POS_CHAR = 3'd2;
  localparam logic [2:0] FUNC_NUM      = 3'd3;
  localparam logic [2:0] FUNC_INIT     = 3'd4;
  localparam logic [2:0] FUNC_CLEAR    = 3'd5;

  localparam logic [1:0] WAIT_NONE  = 2'd0;
  localparam logic [1:0] WAIT_48MS  = 2'd1;
  localparam logic [1:0] WAIT_5MS   = 2'd2;
  localparam logic [1:0] WAIT_150US = 2'd3;

  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  localparam logic [3:0] NIB_WAKE = 4'h3;
  localparam logic [3:0] NIB_4BIT = 4'h2;

  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CMD_FUNC_SET = 8'h28;
  localparam logic [7:0] CMD_DISP_ON  = 8'h0F;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_ENTRY    = 8'h06;
  localparam logic [7:0] CMD_HOME     = 8'h02;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] value;
    logic        row;
    logic [5:0]  col;
  } lcdns_in_t;

  typedef struct packed {
    logic       rs;
    logic [3:0] nibble;
    logic [1:0] wait_class;
    logic       last;
  } lcdns_out_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  data;
    logic [7:0]  pos;
    logic [15:0] value;
  } entry_t;

  typedef struct packed {
    logic               empty;
    logic               full;
    logic [FIFO_CW-1:0] count;
  } fifo_stat_t;

  function automatic logic [3:0] last_step(input logic [2:0] func);
    logic [3:0] s;
    case (func)
      FUNC_CMD, FUNC_CHAR:       s = 4'd1;
      FUNC_POS_CHAR, FUNC_CLEAR: s = 4'd3;
      FUNC_NUM:                  s = 4'd11;
      FUNC_INIT:                 s = 4'd15;
      default:                   s = 4'd1;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = CMD_FUNC_SET;
      3'd1:    c = CMD_DISP_ON;
      3'd2:    c = CMD_CLEAR;
      3'd3:    c = CMD_ENTRY;
      3'd4:    c = CMD_HOME;
      3'd5:    c = CMD_CLEAR;
      default: c = CMD_CLEAR;
    endcase
    return c;
  endfunction

  function automatic logic [13:0] dec_weight(input logic [2:0] idx);
    logic [13:0] w;
    case (idx)
      3'd0:    w = 14'd10000;
      3'd1:    w = 14'd1000;
      3'd2:    w = 14'd100;
      3'd3:    w = 14'd10;
      default: w = 14'd1;
    endcase
    return w;
  endfunction

  // Remainder is below ten times the weight, so nine parallel compares suffice.
  function automatic logic [3:0] dec_digit(input logic [15:0] r, input logic [13:0] w);
    logic [3:0] d;
    d = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if ({1'b0, r} >= 17'(k) * {3'b0, w}) begin
        d = 4'(k);
      end
    end
    return d;
  endfunction

endpackage

// ===== design/lcdns_front.sv =====
// ----------------------------------------------------------------------------
// lcdns_front - request intake
// Accepts requests, drops unused codes and builds the queue entry.
// ----------------------------------------------------------------------------
module lcdns_front
  import lcdns_pkg::*;
(
  input  logic       in_valid,
  output logic       in_ready,
  input  lcdns_in_t  in_data,
  input  fifo_stat_t stat,
  output logic       push,
  output entry_t     push_entry
);

  assign in_ready = !stat.full;
  assign push     = in_valid && in_ready && (in_data.func <= FUNC_CLEAR);

  always_comb begin
    push_entry.func  = in_data.func;
    push_entry.data  = in_data.value[7:0];
    push_entry.pos   = {1'b1, in_data.row, in_data.col};
    push_entry.value = in_data.value;
  end

endmodule

// ===== design/lcdns_fifo.sv =====
// ----------------------------------------------------------------------------
// lcdns_fifo - request queue
// Short queue between intake and transfer sequencer.
// ----------------------------------------------------------------------------
module lcdns_fifo
  import lcdns_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  entry_t     push_entry,
  input  logic       pop,
  output entry_t     head,
  output fifo_stat_t stat
);

  entry_t             mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;

  function automatic logic [FIFO_AW-1:0] ptr_inc(input logic [FIFO_AW-1:0] p);
    return (p == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_AW'(1);
  endfunction

  assign head       = mem[rd_ptr];
  assign stat.count = count;
  assign stat.empty = (count == '0);
  assign stat.full  = (count == FIFO_CW'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + FIFO_CW'(1);
      end else if (pop && !push) begin
        count <= count - FIFO_CW'(1);
      end
    end
  end

endmodule

// ===== design/lcdns_back.sv =====
// ----------------------------------------------------------------------------
// lcdns_back - transfer sequencer
// Steps through the nibble transfers of one request into the output register,
// one per cycle unless the output stalls; decimal digits are peeled one per byte.
// ----------------------------------------------------------------------------
module lcdns_back
  import lcdns_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  fifo_stat_t stat,
  input  entry_t     head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output lcdns_out_t out_data
);

  logic        busy;
  logic [3:0]  step;
  entry_t      cur;
  logic [15:0] rem;
  logic        seen;
  logic [3:0]  char_lo;

  entry_t      ent;
  logic [3:0]  stp;
  logic [15:0] r;
  logic        sn;
  logic        fire;
  logic        is_last;
  logic        dig_step;
  logic [2:0]  nb;
  logic [13:0] w;
  logic [3:0]  d;
  logic        blank;
  logic [7:0]  ch;
  logic [17:0] prod;
  logic [7:0]  sel_byte;
  logic        rs_sel;
  logic [3:0]  nib_sel;
  logic [1:0]  wc_sel;

  assign ent     = busy ? cur : head;
  assign stp     = busy ? step : '0;
  assign r       = busy ? rem : head.value;
  assign sn      = busy && seen;
  assign fire    = (busy || !stat.empty) && (!out_valid || out_ready);
  assign pop     = fire && !busy;
  assign is_last = (stp == last_step(ent.func));

  assign dig_step = (ent.func == FUNC_NUM) && (stp >= 4'd2) && !stp[0];
  assign nb       = 3'(stp[3:1] - 3'd1);
  assign w        = dec_weight(nb);
  assign d        = dec_digit(r, w);
  assign blank    = (nb != 3'd4) && (d == 4'd0) && !sn;
  assign ch       = blank ? CH_SPACE : (CH_ZERO | {4'b0, d});
  assign prod     = {4'b0, w} * {14'b0, d};

  always_comb begin
    sel_byte = ent.data;
    rs_sel   = RS_CMD;
    wc_sel   = WAIT_NONE;
    case (ent.func)
      FUNC_CMD: begin
        sel_byte = ent.data;
      end
      FUNC_CHAR: begin
        sel_byte = ent.data;
        rs_sel   = RS_DATA;
      end
      FUNC_POS_CHAR: begin
        sel_byte = (stp < 4'd2) ? ent.pos : ent.data;
        rs_sel   = (stp < 4'd2) ? RS_CMD : RS_DATA;
      end
      FUNC_NUM: begin
        sel_byte = (stp < 4'd2) ? ent.pos : ch;
        rs_sel   = (stp < 4'd2) ? RS_CMD : RS_DATA;
      end
      FUNC_INIT: begin
        sel_byte = init_cmd(3'(stp[3:1] - 3'd2));
      end
      FUNC_CLEAR: begin
        sel_byte = (stp < 4'd2) ? CMD_HOME : CMD_CLEAR;
      end
      default: begin
        sel_byte = ent.data;
      end
    endcase

    nib_sel = stp[0] ? sel_byte[3:0] : sel_byte[7:4];
    if ((ent.func == FUNC_NUM) && (stp >= 4'd2) && stp[0]) begin
      nib_sel = char_lo;
    end
    if ((ent.func == FUNC_INIT) && (stp < 4'd4)) begin
      nib_sel = (stp == 4'd3) ? NIB_4BIT : NIB_WAKE;
      case (stp[1:0])
        2'd0:    wc_sel = WAIT_48MS;
        2'd1:    wc_sel = WAIT_5MS;
        2'd2:    wc_sel = WAIT_150US;
        default: wc_sel = WAIT_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= '0;
      out_valid <= 1'b0;
    end else if (fire) begin
      busy      <= !is_last;
      step      <= stp + 4'd1;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      cur                 <= ent;
      out_data.rs         <= rs_sel;
      out_data.nibble     <= nib_sel;
      out_data.wait_class <= wc_sel;
      out_data.last       <= is_last;
      if (dig_step) begin
        rem     <= r - prod[15:0];
        seen    <= sn || !blank;
        char_lo <= ch[3:0];
      end else begin
        rem  <= r;
        seen <= sn;
      end
    end
  end

endmodule

// ===== design/char_lcd_nibble_sequencer_top.sv =====
// The first nibble of a request accepted into an empty queue is registered in the
// queue and then in the output register. One nibble per cycle while out_ready does
// not stall the output; a request has 2 to 16 transfers, set by the sequencer.
// Up to two requests wait in the queue while the sequencer works.
// Reset (synchronous) empties the queue and the output register.
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_top - 4-bit character LCD transfer sequencer
// Intake and queue feed a sequencer that emits nibble transfers per request.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_top
  import lcdns_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  lcdns_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output lcdns_out_t out_data
);

  fifo_stat_t stat;
  entry_t     push_entry;
  entry_t     head;
  logic       push;
  logic       pop;

  lcdns_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .stat       (stat),
    .push       (push),
    .push_entry (push_entry)
  );

  lcdns_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (stat)
  );

  lcdns_back u_back (
    .clk       (clk),
    .rst       (rst),
    .stat      (stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    stat.count <= FIFO_CW'(FIFO_DEPTH))
    else $error("request queue over capacity");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !stat.full)
    else $error("request pushed into full queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty)
    else $error("request popped from empty queue");

  a_wait_cmd: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.wait_class != WAIT_NONE)) |->
      ((out_data.rs == RS_CMD) && !out_data.last))
    else $error("wait class outside init prefix");
`endif

endmodule
